// ----- hdl/mdas_pkg.sv -----
// shared types and constants of the multidimensional array store
package mdas_pkg;

    localparam int INDEX_WIDTH      = 13;
    localparam int BOUND_WIDTH      = 13;
    localparam int VALUE_WIDTH      = 32;
    localparam int OFFSET_WIDTH     = 12;
    localparam int DIMS_WIDTH       = 3;
    localparam int NUM_INDEX_FIELDS = 4;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 13;

    localparam int VALUE_LSB       = NUM_INDEX_FIELDS * INDEX_WIDTH;
    localparam int S_TDATA_WIDTH   = ((VALUE_LSB + VALUE_WIDTH + 7) / 8) * 8;
    localparam int RESULT_WIDTH    = VALUE_WIDTH + 2 + OFFSET_WIDTH;
    localparam int M_TDATA_WIDTH   = ((RESULT_WIDTH + 7) / 8) * 8;

    localparam int QUEUE_DEPTH     = 8;
    localparam int QCOUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_DIMS    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOUND_FIRST = 3'd1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SHAPE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SHAPE,
        SEQ_STRIDE
    } seq_state_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  read_value;
        status_t                 status;
        logic [OFFSET_WIDTH-1:0] element_offset;
    } result_t;

endpackage

// ----- hdl/mdas_ram.sv -----
// generic single-port synchronous ram with registered read
module mdas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/mdas_shape.sv -----
// shape registers, capacity check and row-major stride derivation
module mdas_shape #(
    parameter int MAX_DIMS     = 4,
    parameter int CAPACITY     = 4096,
    parameter int STRIDE_WIDTH = 13
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mdas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mdas_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output logic [mdas_pkg::DIMS_WIDTH-1:0]      dims,
    output logic [mdas_pkg::BOUND_WIDTH-1:0]     bounds [MAX_DIMS],
    output logic [STRIDE_WIDTH-1:0]              strides [MAX_DIMS],
    output logic                                 fits,
    output logic                                 busy
);

    localparam int MW  = STRIDE_WIDTH + mdas_pkg::BOUND_WIDTH;
    localparam int NBR = (MAX_DIMS < mdas_pkg::NUM_INDEX_FIELDS) ?
                         MAX_DIMS : mdas_pkg::NUM_INDEX_FIELDS;
    localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);
    localparam logic [STRIDE_WIDTH-1:0] SAT = STRIDE_WIDTH'(CAPACITY + 1);
    localparam logic [STRIDE_WIDTH-1:0] ONE = STRIDE_WIDTH'(1);
    localparam logic [mdas_pkg::DIMS_WIDTH-1:0] DIMS_MAX =
        mdas_pkg::DIMS_WIDTH'(MAX_DIMS);
    localparam logic [mdas_pkg::DIMS_WIDTH-1:0] DIMS_ONE =
        mdas_pkg::DIMS_WIDTH'(1);

    mdas_pkg::seq_state_t state_reg, state_next;

    logic [mdas_pkg::DIMS_WIDTH-1:0]  num_dims_reg;
    logic [mdas_pkg::BOUND_WIDTH-1:0] bound_reg [MAX_DIMS];
    logic [STRIDE_WIDTH-1:0]          stride_reg [MAX_DIMS];
    logic [STRIDE_WIDTH-1:0]          acc_reg, acc_next;
    logic [mdas_pkg::DIMS_WIDTH-1:0]  k_reg, k_next;
    logic                             over_reg, over_next;
    logic                             fits_reg, fits_next;
    logic                             stride_wr;

    logic [mdas_pkg::BOUND_WIDTH-1:0] sel_bound;
    logic [MW-1:0]                    mul;
    logic                             mul_over;
    logic [STRIDE_WIDTH-1:0]          mul_sat;
    logic                             last_dim;

    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            dims = DIMS_ONE;
        end
        else if (num_dims_reg > DIMS_MAX)
        begin
            dims = DIMS_MAX;
        end
        else
        begin
            dims = num_dims_reg;
        end
    end

    always_comb
    begin
        sel_bound = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (k_reg == mdas_pkg::DIMS_WIDTH'(d))
            begin
                sel_bound = bound_reg[d];
            end
        end
    end

    assign mul      = MW'(acc_reg) * MW'(sel_bound);
    assign mul_over = mul > CAP_M;
    assign mul_sat  = mul_over ? SAT : STRIDE_WIDTH'(mul);
    assign last_dim = k_reg == (dims - DIMS_ONE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        priority if (cfg_we)
        begin
            state_next = mdas_pkg::SEQ_SHAPE;
        end
        else
        begin
            unique case (state_reg)
                mdas_pkg::SEQ_IDLE:
                begin
                    state_next = mdas_pkg::SEQ_IDLE;
                end
                mdas_pkg::SEQ_SHAPE:
                begin
                    if (last_dim)
                    begin
                        state_next = (dims == DIMS_ONE) ? mdas_pkg::SEQ_IDLE :
                                                          mdas_pkg::SEQ_STRIDE;
                    end
                end
                mdas_pkg::SEQ_STRIDE:
                begin
                    if (k_reg == DIMS_ONE)
                    begin
                        state_next = mdas_pkg::SEQ_IDLE;
                    end
                end
                default:
                begin
                    state_next = mdas_pkg::SEQ_IDLE;
                end
            endcase
        end
    end

    // datapath control
    always_comb
    begin
        acc_next  = acc_reg;
        k_next    = k_reg;
        over_next = over_reg;
        fits_next = fits_reg;
        stride_wr = 1'b0;
        priority if (cfg_we)
        begin
            acc_next  = ONE;
            k_next    = '0;
            over_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                mdas_pkg::SEQ_IDLE:
                begin
                end
                mdas_pkg::SEQ_SHAPE:
                begin
                    // running product of the bounds, frozen once over capacity
                    if (!over_reg)
                    begin
                        acc_next  = mul_sat;
                        over_next = mul_over;
                    end
                    k_next = k_reg + DIMS_ONE;
                    if (last_dim)
                    begin
                        fits_next = !over_next;
                        acc_next  = ONE;
                        k_next    = dims - DIMS_ONE;
                    end
                end
                mdas_pkg::SEQ_STRIDE:
                begin
                    acc_next  = mul_sat;
                    stride_wr = 1'b1;
                    k_next    = k_reg - DIMS_ONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mdas_pkg::SEQ_IDLE;
            num_dims_reg <= DIMS_ONE;
            acc_reg      <= ONE;
            k_reg        <= '0;
            over_reg     <= 1'b0;
            fits_reg     <= 1'b1;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                bound_reg[d]  <= mdas_pkg::BOUND_WIDTH'(1);
                stride_reg[d] <= ONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            k_reg     <= k_next;
            over_reg  <= over_next;
            fits_reg  <= fits_next;
            if (cfg_we)
            begin
                if (cfg_index == mdas_pkg::CFG_NUM_DIMS)
                begin
                    num_dims_reg <= cfg_data[mdas_pkg::DIMS_WIDTH-1:0];
                end
                for (int d = 0; d < NBR; d++)
                begin
                    if (cfg_index == mdas_pkg::CFG_BOUND_FIRST +
                                     mdas_pkg::CFG_INDEX_WIDTH'(d))
                    begin
                        bound_reg[d] <= cfg_data;
                    end
                end
                for (int d = 0; d < MAX_DIMS; d++)
                begin
                    stride_reg[d] <= ONE;
                end
            end
            else if (stride_wr)
            begin
                for (int d = 0; d < MAX_DIMS - 1; d++)
                begin
                    if (k_reg == mdas_pkg::DIMS_WIDTH'(d + 1))
                    begin
                        stride_reg[d] <= mul_sat;
                    end
                end
            end
        end
    end

    assign bounds  = bound_reg;
    assign strides = stride_reg;
    assign fits    = fits_reg;
    assign busy    = state_reg != mdas_pkg::SEQ_IDLE;

endmodule

// ----- hdl/mdas_access.sv -----
// access pipeline: range check, stride products, offset sum, element ram
module mdas_access #(
    parameter int MAX_DIMS      = 4,
    parameter int CAPACITY      = 4096,
    parameter int ELEMENT_WIDTH = 32,
    parameter int STRIDE_WIDTH  = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_mode,
    input  logic [mdas_pkg::INDEX_WIDTH-1:0]  in_index [mdas_pkg::NUM_INDEX_FIELDS],
    input  logic [mdas_pkg::VALUE_WIDTH-1:0]  in_value,
    input  logic [mdas_pkg::DIMS_WIDTH-1:0]   dims,
    input  logic [mdas_pkg::BOUND_WIDTH-1:0]  bounds [MAX_DIMS],
    input  logic [STRIDE_WIDTH-1:0]           strides [MAX_DIMS],
    input  logic                              fits,
    output logic                              out_valid,
    output mdas_pkg::result_t                 out_result,
    output logic [1:0]                        inflight
);

    localparam int AW = $clog2(CAPACITY);
    localparam int MAGW = mdas_pkg::INDEX_WIDTH - 1;
    localparam int PW = STRIDE_WIDTH + MAGW;

    logic [mdas_pkg::INDEX_WIDTH-1:0] idx_in [MAX_DIMS];

    genvar g;
    for (g = 0; g < MAX_DIMS; g++)
    begin : g_idx
        if (g < mdas_pkg::NUM_INDEX_FIELDS)
        begin : g_field
            assign idx_in[g] = in_index[g];
        end
        else
        begin : g_zero
            assign idx_in[g] = '0;
        end
    end

    // stage 0: captured item
    logic                             v0_reg;
    logic                             mode0_reg;
    logic [mdas_pkg::INDEX_WIDTH-1:0] idx0_reg [MAX_DIMS];
    logic [mdas_pkg::VALUE_WIDTH-1:0] wv0_reg;

    // stage 1: products and status
    logic                             v1_reg;
    logic                             mode1_reg;
    logic [mdas_pkg::VALUE_WIDTH-1:0] wv1_reg;
    logic [AW-1:0]                    prod1_reg [MAX_DIMS];
    mdas_pkg::status_t                status1_reg;

    // stage 2: ram access done
    logic                             v2_reg;
    logic                             mode2_reg;
    logic [AW-1:0]                    offset2_reg;
    mdas_pkg::status_t                status2_reg;

    logic [AW-1:0]           prod0 [MAX_DIMS];
    logic [MAX_DIMS-1:0]     bad0;
    mdas_pkg::status_t       status0;
    logic [AW-1:0]           offset_sum;
    logic                    ram_en;
    logic                    ram_ok1;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (mdas_pkg::DIMS_WIDTH'(d) < dims)
            begin
                bad0[d]  = idx0_reg[d][MAGW] ||
                           ({1'b0, idx0_reg[d][MAGW-1:0]} >= bounds[d]);
                prod0[d] = AW'(PW'(strides[d]) * PW'(idx0_reg[d][MAGW-1:0]));
            end
            else
            begin
                bad0[d]  = 1'b0;
                prod0[d] = '0;
            end
        end
    end

    always_comb
    begin
        priority if (!fits)
        begin
            status0 = mdas_pkg::STATUS_SHAPE;
        end
        else if (|bad0)
        begin
            status0 = mdas_pkg::STATUS_RANGE;
        end
        else
        begin
            status0 = mdas_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        offset_sum = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            offset_sum = offset_sum + prod1_reg[d];
        end
    end

    assign ram_ok1 = status1_reg == mdas_pkg::STATUS_OK;
    assign ram_en  = v1_reg && ram_ok1;

    mdas_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (mode1_reg == mdas_pkg::MODE_WRITE),
        .addr  (offset_sum),
        .wdata (ELEMENT_WIDTH'($signed(wv1_reg))),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            mode0_reg <= in_mode;
            wv0_reg   <= in_value;
            idx0_reg  <= idx_in;
        end
        mode1_reg   <= mode0_reg;
        wv1_reg     <= wv0_reg;
        prod1_reg   <= prod0;
        status1_reg <= status0;
        mode2_reg   <= mode1_reg;
        status2_reg <= status1_reg;
        offset2_reg <= ram_ok1 ? offset_sum : '0;
    end

    always_comb
    begin
        out_result.status         = status2_reg;
        out_result.element_offset = mdas_pkg::OFFSET_WIDTH'(offset2_reg);
        if (status2_reg == mdas_pkg::STATUS_OK && mode2_reg == mdas_pkg::MODE_READ)
        begin
            out_result.read_value = mdas_pkg::VALUE_WIDTH'($signed(ram_rdata));
        end
        else
        begin
            out_result.read_value = '0;
        end
    end

    assign out_valid = v2_reg;
    assign inflight  = {1'b0, v0_reg} + {1'b0, v1_reg} + {1'b0, v2_reg};

endmodule

// ----- hdl/mdas_outq.sv -----
// result queue between the access pipeline and the output stream
module mdas_outq #(
    parameter int DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mdas_pkg::result_t     push_data,
    input  logic                  pop_ready,
    output logic                  out_valid,
    output mdas_pkg::result_t     out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);

    mdas_pkg::result_t entry_reg [DEPTH];
    logic [PTRW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]     count_reg;
    logic              pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && pop_ready;
    assign out_data  = entry_reg[rptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + PTRW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/multidim_array_store.sv -----
// top level of the multidimensional array store
// Row-major array of up to MAX_DIMS dimensions in a single-port element ram
// of CAPACITY entries. One access per clock is taken while the result queue
// has room; each result passes the capture, product and ram stages, behind the
// ram's registered read, into the result queue. The element ram is shared by
// reads and writes on a single port, one access per cycle, so a read right
// after a write to the same element sees the new value. After every
// configuration write the strides and the capacity check are derived again
// with one shared multiplier; input tready is low during that pass. The element
// ram has no reset: an element reads back only after it has been written.
module multidim_array_store #(
    parameter int MAX_DIMS      = 4,
    parameter int CAPACITY      = 4096,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mdas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mdas_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // index_0, index_1, index_2, index_3, write_value
    input  logic [mdas_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    // mode
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // read_value, status, element_offset
    output logic [mdas_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    localparam int STRIDE_WIDTH = $clog2(CAPACITY + 2);
    localparam int CREDIT_WIDTH = mdas_pkg::QCOUNT_WIDTH + 1;

    logic [mdas_pkg::DIMS_WIDTH-1:0]  dims;
    logic [mdas_pkg::BOUND_WIDTH-1:0] bounds [MAX_DIMS];
    logic [STRIDE_WIDTH-1:0]          strides [MAX_DIMS];
    logic                             fits;
    logic                             busy;

    logic [mdas_pkg::INDEX_WIDTH-1:0] in_index [mdas_pkg::NUM_INDEX_FIELDS];
    logic                             in_xfer;
    logic                             res_valid;
    mdas_pkg::result_t                res;
    logic [1:0]                       inflight;
    mdas_pkg::result_t                q_data;
    logic [mdas_pkg::QCOUNT_WIDTH-1:0] q_count;
    logic [CREDIT_WIDTH-1:0]          credit;

    genvar g;
    for (g = 0; g < mdas_pkg::NUM_INDEX_FIELDS; g++)
    begin : g_unpack
        assign in_index[g] = s_tdata[g*mdas_pkg::INDEX_WIDTH +: mdas_pkg::INDEX_WIDTH];
    end

    // every transfer in flight holds a queue slot
    assign credit   = CREDIT_WIDTH'(q_count) + CREDIT_WIDTH'(inflight);
    assign s_tready = !busy && (credit < CREDIT_WIDTH'(mdas_pkg::QUEUE_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;

    mdas_shape #(
        .MAX_DIMS     (MAX_DIMS),
        .CAPACITY     (CAPACITY),
        .STRIDE_WIDTH (STRIDE_WIDTH)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims),
        .bounds    (bounds),
        .strides   (strides),
        .fits      (fits),
        .busy      (busy)
    );

    mdas_access #(
        .MAX_DIMS      (MAX_DIMS),
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .STRIDE_WIDTH  (STRIDE_WIDTH)
    ) u_access (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_xfer),
        .in_mode    (s_tuser[0]),
        .in_index   (in_index),
        .in_value   (s_tdata[mdas_pkg::VALUE_LSB +: mdas_pkg::VALUE_WIDTH]),
        .dims       (dims),
        .bounds     (bounds),
        .strides    (strides),
        .fits       (fits),
        .out_valid  (res_valid),
        .out_result (res),
        .inflight   (inflight)
    );

    mdas_outq #(
        .DEPTH (mdas_pkg::QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_tdata = mdas_pkg::M_TDATA_WIDTH'({q_data.element_offset, q_data.status,
                                               q_data.read_value});

endmodule

// ----- verif/tb_multidim_array_store.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the multidimensional array store: shaped accesses vs a predictor
module tb_multidim_array_store;
    import mdas_pkg::*;

    localparam int CAPACITY        = 4096;
    localparam int MAX_DIMS        = 4;
    localparam int RANDOM_PHASES   = 15;
    localparam int PHASE_ACCESSES  = 100;
    localparam int MAX_BOUND_VALUE = (1 << BOUND_WIDTH) - 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BOUND_LAST =
        CFG_BOUND_FIRST + CFG_INDEX_WIDTH'(3);

    typedef struct packed {
        logic                                         mode;
        logic [NUM_INDEX_FIELDS-1:0][INDEX_WIDTH-1:0] index;
        logic [VALUE_WIDTH-1:0]                       write_value;
    } access_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    // index_0, index_1, index_2, index_3, write_value
    logic [S_TDATA_WIDTH-1:0]   s_tdata   = '0;
    // mode
    logic [0:0]                 s_tuser   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    // read_value, status, element_offset
    logic [M_TDATA_WIDTH-1:0]   m_tdata;

    // shape copy and element image of the predictor
    logic [DIMS_WIDTH-1:0]  dims_reg = DIMS_WIDTH'(1);
    logic [BOUND_WIDTH-1:0] dim_bound [MAX_DIMS];
    longint                 row_stride [MAX_DIMS];
    logic [VALUE_WIDTH-1:0] element_model [CAPACITY];
    bit                     element_written [CAPACITY];

    access_t pending_access [$];
    access_t phase_targets [$];
    result_t expected_result [$];

    access_t                 offered;
    result_t                 predicted;
    result_t                 want;
    logic [OFFSET_WIDTH-1:0] predicted_offset;
    logic [VALUE_WIDTH-1:0]  got_value;
    logic [1:0]              got_status;
    logic [OFFSET_WIDTH-1:0] got_offset;

    int   tx_gap, rx_stall;
    bit   calm      = 1'b0;
    logic long_hold = 1'b0;
    int   n_accepted, n_results, mismatches;
    int   n_read_ok, n_write_ok, n_range, n_shape;

    multidim_array_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int dims_in_use(input logic [DIMS_WIDTH-1:0] nd);
        if (nd == 0)
            return 1;
        if (int'(nd) > MAX_DIMS)
            return MAX_DIMS;
        return int'(nd);
    endfunction

    function automatic void derive_strides();
        int n;
        int d;
        n = dims_in_use(dims_reg);
        for (d = 0; d < MAX_DIMS; d++)
            row_stride[d] = 1;
        for (d = n - 2; d >= 0; d--)
            row_stride[d] = longint'(dim_bound[d + 1]) * row_stride[d + 1];
    endfunction

    // size check first, then every used subscript, then the row-major sum
    function automatic status_t locate(input access_t a, output logic [OFFSET_WIDTH-1:0] off);
        int     n;
        int     d;
        longint extent;
        longint sum;
        longint idx;
        n = dims_in_use(dims_reg);
        off = '0;
        extent = 1;
        for (d = 0; d < n; d++)
            extent = extent * longint'(dim_bound[d]);
        if (extent > CAPACITY)
            return STATUS_SHAPE;
        sum = 0;
        for (d = 0; d < n; d++)
        begin
            idx = longint'($signed(a.index[d]));
            if (idx < 0 || idx >= longint'(dim_bound[d]))
                return STATUS_RANGE;
            sum = sum + row_stride[d] * idx;
        end
        off = sum[OFFSET_WIDTH-1:0];
        return STATUS_OK;
    endfunction

    // reads of never-written elements are turned into writes
    function automatic void queue_access(input access_t a);
        logic [OFFSET_WIDTH-1:0] off;
        if (locate(a, off) == STATUS_OK)
        begin
            if (a.mode == MODE_READ && !element_written[off])
                a.mode = MODE_WRITE;
            if (a.mode == MODE_WRITE)
            begin
                element_written[off] = 1'b1;
                phase_targets.push_back(a);
            end
        end
        pending_access.push_back(a);
    endfunction

    function automatic access_t mk_access(input logic mode, input int i0, input int i1,
                                          input int i2, input int i3,
                                          input logic [VALUE_WIDTH-1:0] v);
        access_t a;
        a.mode        = mode;
        a.index[0]    = i0[INDEX_WIDTH-1:0];
        a.index[1]    = i1[INDEX_WIDTH-1:0];
        a.index[2]    = i2[INDEX_WIDTH-1:0];
        a.index[3]    = i3[INDEX_WIDTH-1:0];
        a.write_value = v;
        return a;
    endfunction

    task automatic drain();
        while (pending_access.size() != 0 || s_tvalid || expected_result.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, then wait out the stride pass
    task automatic write_reg(input int idx, input int data);
        logic [CFG_INDEX_WIDTH-1:0] ri;
        logic [CFG_DATA_WIDTH-1:0]  rd;
        ri = CFG_INDEX_WIDTH'(idx);
        rd = CFG_DATA_WIDTH'(data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= rd;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ri == CFG_NUM_DIMS)
            dims_reg = rd[DIMS_WIDTH-1:0];
        else if (ri <= CFG_BOUND_LAST)
            dim_bound[int'(ri - CFG_BOUND_FIRST)] = rd[BOUND_WIDTH-1:0];
        derive_strides();
        repeat (2 * MAX_DIMS + 2) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = '0;
                predicted.status = locate(offered, predicted_offset);
                case (predicted.status)
                    STATUS_OK:
                    begin
                        predicted.element_offset = predicted_offset;
                        if (offered.mode == MODE_WRITE)
                        begin
                            element_model[predicted_offset] = offered.write_value;
                            n_write_ok++;
                        end
                        else
                        begin
                            predicted.read_value = element_model[predicted_offset];
                            n_read_ok++;
                        end
                    end
                    STATUS_RANGE: n_range++;
                    default:      n_shape++;
                endcase
                expected_result.push_back(predicted);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    tx_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end
                else if (pending_access.size() != 0)
                begin
                    offered = pending_access.pop_front();
                    s_tdata  <= S_TDATA_WIDTH'({offered.write_value, offered.index});
                    s_tuser  <= offered.mode;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_value  = m_tdata[VALUE_WIDTH-1:0];
                got_status = m_tdata[VALUE_WIDTH +: 2];
                got_offset = m_tdata[VALUE_WIDTH + 2 +: OFFSET_WIDTH];
                n_results++;
                if (expected_result.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%h status=%0d offset=%0d",
                                 got_value, got_status, got_offset);
                end
                else
                begin
                    want = expected_result.pop_front();
                    if (got_value !== want.read_value || got_status !== want.status ||
                        got_offset !== want.element_offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected value=%h status=%0d offset=%0d, %s",
                                     n_results, want.read_value, want.status,
                                     want.element_offset,
                                     $sformatf("got value=%h status=%0d offset=%0d",
                                               got_value, got_status, got_offset));
                    end
                end
            end
            if (long_hold)
                m_tready <= 1'b0;
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rx_stall = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        while (!(n_accepted >= 300 && pending_access.size() >= 30))
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (64) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", expected_result.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        access_t                a;
        int                     p, k, d, n, pick, flavor, room, cap;
        logic [DIMS_WIDTH-1:0]  nd;
        logic [BOUND_WIDTH-1:0] b [MAX_DIMS];
        for (d = 0; d < MAX_DIMS; d++)
            dim_bound[d] = BOUND_WIDTH'(1);
        derive_strides();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset shape: one dimension holding one element, unused subscripts ignored
        queue_access(mk_access(MODE_WRITE, 0, 0, 0, 0, 32'h7fff_ffff));
        queue_access(mk_access(MODE_READ, 0, -4096, 4095, -1, 32'h0));
        queue_access(mk_access(MODE_WRITE, -1, 0, 0, 0, 32'h1234_5678));
        queue_access(mk_access(MODE_READ, 1, 0, 0, 0, 32'h0));
        queue_access(mk_access(MODE_READ, 4095, 0, 0, 0, 32'h0));
        queue_access(mk_access(MODE_WRITE, -4096, 0, 0, 0, 32'hffff_ffff));
        drain();

        // four dimensions filling the store exactly
        write_reg(int'(CFG_NUM_DIMS), 4);
        for (d = 0; d < MAX_DIMS; d++)
            write_reg(int'(CFG_BOUND_FIRST) + d, 8);
        queue_access(mk_access(MODE_WRITE, 7, 7, 7, 7, 32'h8000_0000));
        queue_access(mk_access(MODE_WRITE, 0, 0, 0, 0, 32'hffff_ffff));
        queue_access(mk_access(MODE_READ, 7, 7, 7, 7, 32'h0));
        queue_access(mk_access(MODE_READ, 0, 0, 0, 0, 32'h0));
        queue_access(mk_access(MODE_READ, 7, 7, 7, 8, 32'h0));
        queue_access(mk_access(MODE_WRITE, 3, -1, 2, 1, 32'h0));
        drain();

        // dimension count above the limit, shape over capacity
        write_reg(int'(CFG_NUM_DIMS), 7);
        write_reg(int'(CFG_BOUND_LAST), 9);
        queue_access(mk_access(MODE_READ, 0, 0, 0, 0, 32'h0));
        queue_access(mk_access(MODE_WRITE, -4096, 4095, 0, 0, 32'h5555_aaaa));
        drain();

        // zero dimension count, largest bound register value
        write_reg(int'(CFG_NUM_DIMS), 0);
        write_reg(int'(CFG_BOUND_FIRST), MAX_BOUND_VALUE);
        queue_access(mk_access(MODE_WRITE, 1, 0, 0, 0, 32'h0));
        drain();

        write_reg(int'(CFG_BOUND_FIRST), CAPACITY);
        queue_access(mk_access(MODE_WRITE, 4095, 0, 0, 0, 32'h0000_0000));
        queue_access(mk_access(MODE_READ, 4095, 0, 0, 0, 32'h0));
        drain();

        // zero bound, then writes to unknown register indexes
        write_reg(int'(CFG_NUM_DIMS), 2);
        write_reg(int'(CFG_BOUND_FIRST) + 1, 0);
        for (d = int'(CFG_BOUND_LAST) + 1; d < (1 << CFG_INDEX_WIDTH); d++)
            write_reg(d, MAX_BOUND_VALUE);
        queue_access(mk_access(MODE_WRITE, 0, 0, 0, 0, 32'h0));
        queue_access(mk_access(MODE_READ, 5, 0, 0, 0, 32'h0));
        drain();

        write_reg(int'(CFG_BOUND_FIRST) + 1, 1);
        queue_access(mk_access(MODE_READ, 4095, 0, 0, 0, 32'h0));

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p == RANDOM_PHASES - 2)
                calm <= 1'b1;

            // mostly shapes that fit, some oversized, some with an empty dimension
            nd = DIMS_WIDTH'($urandom_range(0, 7));
            n = dims_in_use(nd);
            flavor = $urandom_range(0, 9);
            room = CAPACITY;
            for (d = 0; d < MAX_DIMS; d++)
            begin
                if (d >= n || flavor == 0)
                    b[d] = BOUND_WIDTH'($urandom_range(0, MAX_BOUND_VALUE));
                else
                begin
                    cap = (n == 1) ? room : ((room > 64) ? 64 : room);
                    b[d] = BOUND_WIDTH'($urandom_range(1, cap));
                    room = room / int'(b[d]);
                end
            end
            if (flavor == 1)
                b[$urandom_range(0, n - 1)] = '0;
            write_reg(int'(CFG_NUM_DIMS), int'(nd));
            for (d = 0; d < MAX_DIMS; d++)
                write_reg(int'(CFG_BOUND_FIRST) + d, int'(b[d]));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(int'(CFG_BOUND_LAST) + 1, 7),
                          $urandom_range(0, MAX_BOUND_VALUE));
            phase_targets.delete();

            for (k = 0; k < PHASE_ACCESSES; k++)
            begin
                pick = $urandom_range(0, 9);
                a.mode = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 11))
                    0:       a.write_value = 32'h8000_0000;
                    1:       a.write_value = 32'h7fff_ffff;
                    2:       a.write_value = 32'hffff_ffff;
                    default: a.write_value = $urandom();
                endcase
                for (d = 0; d < NUM_INDEX_FIELDS; d++)
                begin
                    if (pick >= 2 && d < n && dim_bound[d] != 0)
                        a.index[d] = INDEX_WIDTH'($urandom_range(0, int'(dim_bound[d]) - 1));
                    else
                        a.index[d] = INDEX_WIDTH'($urandom_range(0, (1 << INDEX_WIDTH) - 1));
                end
                // read back something stored earlier under this shape
                if (pick >= 2 && pick < 6 && phase_targets.size() != 0)
                begin
                    a.index = phase_targets[$urandom_range(0, phase_targets.size() - 1)].index;
                    a.mode = MODE_READ;
                end
                queue_access(a);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("%0d accesses over %0d random shapes and directed corners", n_accepted,
                 RANDOM_PHASES);
        $display("%0d reads and %0d writes in range, %0d out of range, %0d over capacity",
                 n_read_ok, n_write_ok, n_range, n_shape);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
